// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion helpers
// Both macros expect clk_i in the enclosing scope; SAB_ASSERT also expects rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SAB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/sab_pkg.sv =====
// ----------------------------------------------------------------------------
// sab_pkg
// Types, codes and constants of the sprite attribute builder.
// ----------------------------------------------------------------------------
package sab_pkg;

  localparam int unsigned MAX_SPRITES = 80;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned CULL_W      = 20;

  localparam logic signed [CULL_W-1:0] SCREEN_W   = 20'sd320;
  localparam logic signed [CULL_W-1:0] SCREEN_H   = 20'sd224;
  localparam logic signed [CULL_W-1:0] Y_WIN_HI   = 20'sd256;
  localparam logic signed [CULL_W-1:0] Y_WIN_LO   = -20'sd32;
  localparam logic [15:0]              SCREEN_OFS = 16'h0080;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_OBJECT = 2'd1,
    OP_PIECE  = 2'd2
  } sab_op_e;

  typedef enum logic [1:0] {
    CAM_SCREEN = 2'd0,
    CAM_FG     = 2'd1,
    CAM_BG     = 2'd2,
    CAM_THIRD  = 2'd3
  } sab_cam_e;

  typedef enum logic [2:0] {
    REG_FG_CAMERA_X    = 3'd0,
    REG_FG_CAMERA_Y    = 3'd1,
    REG_BG_CAMERA_X    = 3'd2,
    REG_BG_CAMERA_Y    = 3'd3,
    REG_THIRD_CAMERA_X = 3'd4,
    REG_THIRD_CAMERA_Y = 3'd5,
    REG_SIDE_MARGIN    = 3'd6
  } sab_reg_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [1:0]         camera_select;
    logic [7:0]         half_width;
    logic [7:0]         half_height;
    logic               flip_x;
    logic               flip_y;
    logic               custom_height;
    logic [15:0]        tile_base;
    logic [39:0]        piece_bytes;
  } sab_item_t;

  typedef struct packed {
    logic               written;
    logic               visible;
    logic [CNT_W-1:0]   entry_index;
    logic signed [15:0] entry_y;
    logic [5:0]         size_byte;
    logic [CNT_W-1:0]   link;
    logic [15:0]        pattern;
    logic signed [15:0] entry_x;
    logic [CNT_W-1:0]   sprite_count;
  } sab_result_t;

endpackage

// ===== hw/rtl/sab_if.sv =====
// ----------------------------------------------------------------------------
// sab_if
// Handshake channels of the sprite attribute builder.
// ----------------------------------------------------------------------------
interface sab_item_if;
  import sab_pkg::*;
  logic      valid;
  logic      ready;
  sab_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sab_result_if;
  import sab_pkg::*;
  logic        valid;
  logic        ready;
  sab_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sab_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/sprite_attribute_builder.sv =====
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle; a stalled result register keeps the item register full.
// Each item updates the frame state in the cycle it leaves the input register.
// Reset (async, active low) clears camera registers, margin, counters and object state.
// ----------------------------------------------------------------------------
// sprite_attribute_builder
// Culls objects against the screen and packs mapping pieces into sprite entries.
// ----------------------------------------------------------------------------
module sprite_attribute_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  sab_cfg_if.sink      cfg_i,
  sab_item_if.sink     item_i,
  sab_result_if.source result_o
);
  import sab_pkg::*;

  // configuration
  logic signed [15:0] fg_cam_x_q, fg_cam_y_q, bg_cam_x_q, bg_cam_y_q;
  logic signed [15:0] th_cam_x_q, th_cam_y_q;
  logic [9:0]         margin_q;

  // frame and object state
  logic [CNT_W-1:0] count_q, count_d;
  logic             shown_q, shown_d;
  logic [15:0]      obj_x_q, obj_x_d, obj_y_q, obj_y_d, obj_tile_q, obj_tile_d;
  logic             obj_mx_q, obj_mx_d, obj_my_q, obj_my_d;

  // pipeline
  logic        s0_valid_q;
  sab_item_t   s0_q;
  logic        res_valid_q;
  sab_result_t res_q, res_d;
  logic        item_valid, item_ready, item_acc;
  logic        res_ready, out_free, s0_go;

  // datapath
  logic signed [15:0]       cam_x, cam_y;
  logic signed [16:0]       rel_x, rel_y;
  logic signed [CULL_W-1:0] rx_ext, ry_ext, w_ext, h_ext, m_ext;
  logic                     cull_x, cull_y, hdr_ok, room;
  logic [15:0]              hdr_x, hdr_y;
  logic [1:0]               wc, hc;
  logic [7:0]               attr;
  logic [10:0]              tile;
  logic [5:0]               w_span, h_span;
  logic [9:0]               xoff, yoff, xraw, yraw;
  logic [15:0]              pat_sum;

  assign cfg_i.ready = 1'b1;

  assign item_valid     = item_i.valid;
  assign res_ready      = result_o.ready;
  assign out_free       = !res_valid_q || res_ready;
  assign s0_go          = s0_valid_q && out_free;
  assign item_ready     = !s0_valid_q || out_free;
  assign item_i.ready   = item_ready;
  assign item_acc       = item_valid && item_ready;
  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_cam_x_q <= '0;
      fg_cam_y_q <= '0;
      bg_cam_x_q <= '0;
      bg_cam_y_q <= '0;
      th_cam_x_q <= '0;
      th_cam_y_q <= '0;
      margin_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_FG_CAMERA_X:    fg_cam_x_q <= cfg_i.wdata;
        REG_FG_CAMERA_Y:    fg_cam_y_q <= cfg_i.wdata;
        REG_BG_CAMERA_X:    bg_cam_x_q <= cfg_i.wdata;
        REG_BG_CAMERA_Y:    bg_cam_y_q <= cfg_i.wdata;
        REG_THIRD_CAMERA_X: th_cam_x_q <= cfg_i.wdata;
        REG_THIRD_CAMERA_Y: th_cam_y_q <= cfg_i.wdata;
        REG_SIDE_MARGIN:    margin_q   <= cfg_i.wdata[9:0];
        default: ;
      endcase
    end
  end

  // header: camera offset and culling
  always_comb begin
    case (s0_q.camera_select)
      CAM_FG:  begin cam_x = fg_cam_x_q; cam_y = fg_cam_y_q; end
      CAM_BG:  begin cam_x = bg_cam_x_q; cam_y = bg_cam_y_q; end
      CAM_THIRD: begin cam_x = th_cam_x_q; cam_y = th_cam_y_q; end
      default: begin cam_x = '0; cam_y = '0; end
    endcase
    rel_x  = 17'(s0_q.pos_x) - 17'(cam_x);
    rel_y  = 17'(s0_q.pos_y) - 17'(cam_y);
    rx_ext = CULL_W'(rel_x);
    ry_ext = CULL_W'(rel_y);
    w_ext  = {{(CULL_W-8){1'b0}}, s0_q.half_width};
    h_ext  = {{(CULL_W-8){1'b0}}, s0_q.half_height};
    m_ext  = {{(CULL_W-10){1'b0}}, margin_q};
    cull_x = (rx_ext + w_ext + m_ext < 0) || (rx_ext - w_ext - m_ext >= SCREEN_W);
    if (s0_q.custom_height) begin
      cull_y = (ry_ext + h_ext < 0) || (ry_ext - h_ext >= SCREEN_H);
    end else begin
      cull_y = (ry_ext < Y_WIN_LO) || (ry_ext >= Y_WIN_HI);
    end
    room = count_q < CNT_W'(MAX_SPRITES);
    if (s0_q.camera_select == CAM_SCREEN) begin
      hdr_ok = room;
      hdr_x  = s0_q.pos_x;
      hdr_y  = s0_q.pos_y;
    end else begin
      hdr_ok = room && !cull_x && !cull_y;
      hdr_x  = rel_x[15:0] + SCREEN_OFS;
      hdr_y  = rel_y[15:0] + SCREEN_OFS;
    end
  end

  // piece: decode, mirror and pack
  always_comb begin
    attr    = s0_q.piece_bytes[23:16];
    wc      = s0_q.piece_bytes[27:26];
    hc      = s0_q.piece_bytes[25:24];
    tile    = {attr[2:0], s0_q.piece_bytes[15:8]};
    w_span  = {3'({1'b0, wc}) + 3'd1, 3'b000};
    h_span  = {3'({1'b0, hc}) + 3'd1, 3'b000};
    xraw    = {{2{s0_q.piece_bytes[7]}}, s0_q.piece_bytes[7:0]};
    yraw    = {{2{s0_q.piece_bytes[39]}}, s0_q.piece_bytes[39:32]};
    xoff    = obj_mx_q ? (10'd0 - xraw - {4'd0, w_span}) : xraw;
    yoff    = obj_my_q ? (10'd0 - yraw - {4'd0, h_span}) : yraw;
    pat_sum = obj_tile_q + {5'd0, tile};
  end

  always_comb begin
    res_d      = '0;
    count_d    = count_q;
    shown_d    = shown_q;
    obj_x_d    = obj_x_q;
    obj_y_d    = obj_y_q;
    obj_tile_d = obj_tile_q;
    obj_mx_d   = obj_mx_q;
    obj_my_d   = obj_my_q;
    case (s0_q.operation)
      OP_START: begin
        count_d = '0;
        shown_d = 1'b0;
      end
      OP_OBJECT: begin
        shown_d       = hdr_ok;
        res_d.visible = hdr_ok;
        if (hdr_ok) begin
          obj_x_d    = hdr_x;
          obj_y_d    = hdr_y;
          obj_tile_d = s0_q.tile_base;
          obj_mx_d   = s0_q.flip_x;
          obj_my_d   = s0_q.flip_y;
        end
      end
      OP_PIECE: begin
        if (shown_q && room) begin
          count_d           = count_q + 1'b1;
          res_d.written     = 1'b1;
          res_d.entry_index = count_q;
          res_d.link        = count_q + 1'b1;
          res_d.entry_x     = obj_x_q + {{6{xoff[9]}}, xoff};
          res_d.entry_y     = obj_y_q + {{6{yoff[9]}}, yoff};
          res_d.size_byte   = {wc, 2'b00, hc};
          res_d.pattern     = (pat_sum | {attr[7:3], 11'd0}) ^ {3'd0, obj_my_q, obj_mx_q, 11'd0};
        end
      end
      default: ;
    endcase
    // a start beat reports the count it clears
    res_d.sprite_count = (s0_q.operation == OP_START) ? count_q : count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      count_q     <= '0;
      shown_q     <= 1'b0;
      obj_x_q     <= '0;
      obj_y_q     <= '0;
      obj_tile_q  <= '0;
      obj_mx_q    <= 1'b0;
      obj_my_q    <= 1'b0;
    end else begin
      if (item_acc) begin
        s0_valid_q <= 1'b1;
      end else if (s0_go) begin
        s0_valid_q <= 1'b0;
      end
      if (s0_go) begin
        res_valid_q <= 1'b1;
        count_q     <= count_d;
        shown_q     <= shown_d;
        obj_x_q     <= obj_x_d;
        obj_y_q     <= obj_y_d;
        obj_tile_q  <= obj_tile_d;
        obj_mx_q    <= obj_mx_d;
        obj_my_q    <= obj_my_d;
      end else if (res_ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      s0_q <= item_i.data;
    end
    if (s0_go) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== hw/rtl/sab_checker.sv =====
// ----------------------------------------------------------------------------
// sab_checker
// Result channel checks for the sprite attribute builder, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sab_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input sab_pkg::sab_result_t out_data_i
);
  import sab_pkg::*;

  `SAB_ASSERT(a_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i), "result changed while stalled")
  `SAB_ASSERT(a_entry_link, out_valid_i && out_data_i.written |-> out_data_i.link == out_data_i.entry_index + 1'b1 && out_data_i.sprite_count == out_data_i.link, "entry link or count mismatch")
  `SAB_ASSERT(a_entry_excl, out_valid_i && out_data_i.written |-> !out_data_i.visible && out_data_i.entry_index < CNT_W'(MAX_SPRITES), "bad written entry")
  `SAB_ASSERT(a_count_max, out_valid_i |-> out_data_i.sprite_count <= CNT_W'(MAX_SPRITES), "sprite count above maximum")
  `SAB_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_i, "result valid during reset")

endmodule

bind sprite_attribute_builder sab_checker u_sab_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_valid_q),
  .out_ready_i (res_ready),
  .out_data_i  (res_q)
);
